// File: rtl/key_click_classifier_core_assert.svh
// Assertion helpers for the key click classifier. Both expect signals named
// clk and rst_n in the module that uses them.
`ifndef KEY_CLICK_CLASSIFIER_CORE_ASSERT_SVH
`define KEY_CLICK_CLASSIFIER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KCC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/kcc_pkg.sv
`timescale 1ns / 1ps

package kcc_pkg;

    localparam int unsigned COUNT_W = 8;
    localparam int unsigned KEY_W   = 4;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned CFG_W   = 8;
    localparam int unsigned IDX_W   = 1;

    localparam logic [COUNT_W-1:0] COUNT_MAX         = 8'd255;
    localparam logic [COUNT_W-1:0] LATCH_TICK        = 8'd2;
    localparam logic [COUNT_W-1:0] PRESS_CLEAR_AFTER = 8'd3;

    localparam logic [COUNT_W-1:0] SINGLE_DELAY_RST = 8'd30;
    localparam logic [COUNT_W-1:0] LONG_DELAY_RST   = 8'd100;

    localparam logic [IDX_W-1:0] REG_SINGLE_DELAY = 1'b0;
    localparam logic [IDX_W-1:0] REG_LONG_DELAY   = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_SINGLE = 2'd0,
        KIND_DOUBLE = 2'd1,
        KIND_LONG   = 2'd2
    } kind_t;

    typedef struct packed {
        logic [COUNT_W-1:0] release_count;
        logic [COUNT_W-1:0] press_count;
        logic [COUNT_W-1:0] key_history;
    } kcc_state_t;

    typedef struct packed {
        logic             have;
        kind_t            kind;
        logic [KEY_W-1:0] key;
    } kcc_event_t;

endpackage

// File: rtl/key_click_classifier_core.sv
`timescale 1ns / 1ps
`include "key_click_classifier_core_assert.svh"

// Key click classifier.
// Each item on the input channel (in_valid, in_ready, key_code) is one scan
// tick of a keypad: key code 0 means released, any other code means pressed.
// From the run lengths of presses and releases the block reports single,
// double and long clicks on the output channel (out_valid, out_ready,
// event_kind, event_key). A tick gives either no item or exactly one.
// The configuration port (cfg_wr_en, cfg_index, cfg_data) sets the single
// click delay (index 0) and the long click delay (index 1); write it only
// while no tick is in flight.
// A click item appears on the output in the cycle after the tick that causes
// it is accepted. Throughput: one tick per cycle while in_ready is high, set
// by the single registered pass through the counter compare and update logic.
// The output register holds one item: in_ready stays high while the output
// is empty or being taken, so a stalled receiver stops the input only while
// a click item waits on the output. Reset clears the counters and key
// history, restores the delays to 30 and 100 ticks and empties the output.
module key_click_classifier_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [kcc_pkg::IDX_W-1:0]     cfg_index,
    input  logic [kcc_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [kcc_pkg::KEY_W-1:0]     key_code,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [kcc_pkg::KIND_W-1:0]    event_kind,
    output logic [kcc_pkg::KEY_W-1:0]     event_key
);
    import kcc_pkg::*;

    logic [COUNT_W-1:0] single_delay_reg;
    logic [COUNT_W-1:0] long_delay_reg;
    kcc_state_t         state_reg;
    kcc_state_t         state_next;
    kcc_event_t         step_result;
    logic               out_valid_reg;
    logic               out_valid_next;
    kind_t              event_kind_reg;
    logic [KEY_W-1:0]   event_key_reg;
    logic               in_fire;
    logic               click_fire;
    logic               long_fire;
    kind_t              step_kind;

    // The tick is taken whenever the output slot is free or drains this cycle.
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    kcc_step u_step
    (
        .state        (state_reg),
        .key_code     (key_code),
        .single_delay (single_delay_reg),
        .long_delay   (long_delay_reg),
        .state_next   (state_next),
        .result       (step_result)
    );

    // Configuration registers; every index of the port maps to a register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            single_delay_reg <= SINGLE_DELAY_RST;
            long_delay_reg   <= LONG_DELAY_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_SINGLE_DELAY: single_delay_reg <= cfg_data;
                REG_LONG_DELAY:   long_delay_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Classifier state advances once per accepted tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (in_fire)
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_fire)
        begin
            out_valid_next = step_result.have;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // The payload only loads when a tick produces a click.
    always_ff @(posedge clk)
    begin
        if (in_fire && step_result.have)
        begin
            event_kind_reg <= step_result.kind;
            event_key_reg  <= step_result.key;
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_kind = event_kind_reg;
    assign event_key  = event_key_reg;

    assign step_kind  = step_result.kind;
    assign click_fire = in_fire && step_result.have;
    assign long_fire  = click_fire && (step_kind == KIND_LONG);

    `KCC_ASSERT_NEXT(a_quiet_tick, in_fire && !click_fire, !out_valid_reg, "stale output item")
    `KCC_ASSERT_NEXT(a_click_valid, click_fire, out_valid_reg, "click lost on its way out")
    `KCC_ASSERT_NEXT(a_click_kind, click_fire, event_kind_reg == $past(step_kind), "kind altered")
    `KCC_ASSERT_NEXT(a_state_idle, !in_fire, $stable(state_reg), "state moved while idle")
    `KCC_ASSERT_SAME(a_long_press, long_fire, key_code != '0, "long click on release")

endmodule

// File: rtl/kcc_step.sv
`timescale 1ns / 1ps

// Next-state and event logic for one scan tick.
module kcc_step
(
    input  kcc_pkg::kcc_state_t               state,
    input  logic [kcc_pkg::KEY_W-1:0]         key_code,
    input  logic [kcc_pkg::COUNT_W-1:0]       single_delay,
    input  logic [kcc_pkg::COUNT_W-1:0]       long_delay,
    output kcc_pkg::kcc_state_t               state_next,
    output kcc_pkg::kcc_event_t               result
);
    import kcc_pkg::*;

    logic               long_hit;
    logic               latch;
    logic               in_window;
    logic [COUNT_W-1:0] rel_inc;
    logic [COUNT_W-1:0] press_inc;
    logic [COUNT_W-1:0] rel_mid;
    logic [COUNT_W-1:0] single_plus;
    logic [COUNT_W-1:0] long_plus;

    assign rel_inc     = (state.release_count == COUNT_MAX) ? state.release_count
                                                            : COUNT_W'(state.release_count + 1'b1);
    assign press_inc   = (state.press_count == COUNT_MAX) ? state.press_count
                                                          : COUNT_W'(state.press_count + 1'b1);
    assign single_plus = COUNT_W'(single_delay + 1'b1);
    assign long_plus   = COUNT_W'(long_delay + 1'b1);
    assign long_hit    = (state.press_count == long_delay);
    assign latch       = (state.press_count == LATCH_TICK);
    // A long click pushes the release count out of the window before the latch looks at it.
    assign rel_mid     = long_hit ? single_plus : state.release_count;
    assign in_window   = (rel_mid < single_delay);

    always_comb
    begin
        state_next = state;
        result     = '{have: 1'b0, kind: KIND_SINGLE, key: state.key_history[KEY_W-1:0]};
        if (key_code == '0)
        begin
            result.have = (state.release_count == single_delay);
            if (state.release_count > PRESS_CLEAR_AFTER)
            begin
                state_next.press_count = '0;
            end
            state_next.release_count = rel_inc;
        end
        else
        begin
            result.have = long_hit;
            result.kind = KIND_LONG;
            state_next.release_count = rel_mid;
            state_next.press_count   = press_inc;
            if (latch)
            begin
                state_next.key_history = {state.key_history[KEY_W-1:0], key_code};
                if (in_window)
                begin
                    // Press inside the single window: double when the key repeats.
                    result.have = 1'b1;
                    result.kind = (state.key_history[KEY_W-1:0] == key_code) ? KIND_DOUBLE
                                                                            : KIND_SINGLE;
                    result.key  = key_code;
                    state_next.release_count = single_plus;
                    state_next.press_count   = long_plus;
                end
                else
                begin
                    state_next.release_count = '0;
                end
            end
        end
    end

endmodule
